[rtl/core/pqrr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pqrr_pkg
// Shared types, codes and helpers of the priority round-robin scheduler core.
// ----------------------------------------------------------------------------
package pqrr_pkg;

  localparam int PROCESSES_DEF    = 64;
  localparam int POINTER_BITS_DEF = 64;

  localparam int OP_BITS   = 3;
  localparam int ID_BITS   = 6;
  localparam int PRIO_BITS = 8;
  localparam int WORD_PTR  = 64;
  localparam int KIND_BITS = 2;
  localparam int CFG_BITS  = 2;

  typedef enum logic [2:0] {
    OP_CREATE   = 3'd0,
    OP_KILL     = 3'd1,
    OP_BLOCK    = 3'd2,
    OP_UNBLOCK  = 3'd3,
    OP_SET_PRIO = 3'd4,
    OP_SWITCH   = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_READY   = 2'd0,
    ST_RUNNING = 2'd1,
    ST_BLOCKED = 2'd2,
    ST_KILLED  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    MODE_PROC   = 2'd0,
    MODE_KERNEL = 2'd1,
    MODE_NONE   = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    CFG_MIN_PRIO     = 2'd0,
    CFG_MAX_PRIO     = 2'd1,
    CFG_DEFAULT_PRIO = 2'd2
  } cfg_index_t;

  localparam logic [PRIO_BITS-1:0] MIN_PRIO_RST     = 8'd0;
  localparam logic [PRIO_BITS-1:0] MAX_PRIO_RST     = 8'd10;
  localparam logic [PRIO_BITS-1:0] DEFAULT_PRIO_RST = 8'd5;

  // Quantum saturates at zero when the priority exceeds the maximum.
  function automatic logic [PRIO_BITS-1:0] quantum_of(
    input logic [PRIO_BITS-1:0] prio,
    input logic [PRIO_BITS-1:0] max_prio
  );
    quantum_of = (prio > max_prio) ? '0 : max_prio - prio;
  endfunction

endpackage

[rtl/core/pqrr_req_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pqrr_req_if
// Request channel: one scheduler operation per word.
// ----------------------------------------------------------------------------
interface pqrr_req_if;
  logic                             valid;
  logic                             ready;
  logic [pqrr_pkg::OP_BITS-1:0]     operation;
  logic [pqrr_pkg::ID_BITS-1:0]     process_id;
  logic [pqrr_pkg::PRIO_BITS-1:0]   priority_value;
  logic [pqrr_pkg::WORD_PTR-1:0]    context_pointer;

  modport source (output valid, operation, process_id, priority_value, context_pointer,
                  input ready);
  modport sink (input valid, operation, process_id, priority_value, context_pointer,
                output ready);
endinterface

[rtl/core/pqrr_rsp_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pqrr_rsp_if
// Response channel: one result word per operation.
// ----------------------------------------------------------------------------
interface pqrr_rsp_if;
  logic                             valid;
  logic                             ready;
  logic                             failed;
  logic [pqrr_pkg::WORD_PTR-1:0]    resume_pointer;
  logic [pqrr_pkg::ID_BITS-1:0]     running_id;
  logic [pqrr_pkg::KIND_BITS-1:0]   running_kind;
  logic [pqrr_pkg::PRIO_BITS-1:0]   quantum_left;

  modport source (output valid, failed, resume_pointer, running_id, running_kind,
                  quantum_left, input ready);
  modport sink (input valid, failed, resume_pointer, running_id, running_kind,
                quantum_left, output ready);
endinterface

[rtl/core/priority_quantum_round_robin_scheduler_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_quantum_round_robin_scheduler_core
// Process table scheduler with create, kill, block, unblock, priority and
// context switch operations, kept in one synchronous RAM.
// ----------------------------------------------------------------------------
// One request word yields exactly one response word. Create, kill, block,
// unblock and set priority read the entry, update it and present the result.
// A switch picks the preferred or the running entry when it can, and else
// runs a round-robin scan of up to PROCESSES entries, which reads one table
// entry per cycle through the single RAM read port. A new request is taken
// only when the core is idle, but a finished response may still wait in the
// output register. Entry contexts read as zero (free) after reset through
// one valid bit per entry, so no clearing pass is needed.
// Configuration writes are taken at any time but should only be issued idle.
module priority_quantum_round_robin_scheduler_core #(
  parameter int PROCESSES    = pqrr_pkg::PROCESSES_DEF,
  parameter int POINTER_BITS = pqrr_pkg::POINTER_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [pqrr_pkg::CFG_BITS-1:0]   cfg_index,
  input  logic [pqrr_pkg::PRIO_BITS-1:0]  cfg_data,
  pqrr_req_if.sink                        req,
  pqrr_rsp_if.source                      rsp
);
  localparam int IW = (PROCESSES > 1) ? $clog2(PROCESSES) : 1;
  localparam int PW = pqrr_pkg::PRIO_BITS;
  localparam int EW = 2 + PW + POINTER_BITS;
  localparam logic [IW-1:0] LAST_ID = IW'(PROCESSES - 1);

  // Controller states, one-hot.
  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_EXEC    = 6'b000010,
    S_PREF_RD = 6'b000100,
    S_PREF    = 6'b001000,
    S_SCAN    = 6'b010000,
    S_DONE    = 6'b100000
  } state_t;

  state_t state;

  // Configuration registers.
  logic [PW-1:0] min_prio, max_prio, default_prio;

  // Scheduler registers.
  logic [IW-1:0]           running_entry;
  pqrr_pkg::mode_t         running_mode;
  logic [IW-1:0]           preferred_entry;
  logic                    preferred_valid;
  logic [PW-1:0]           quantum_count;
  logic [POINTER_BITS-1:0] kernel_context;

  // Latched request.
  pqrr_pkg::op_t           op_q;
  logic [pqrr_pkg::OP_BITS-1:0] op_raw;
  logic                    id_ok;
  logic [IW-1:0]           id_q;
  logic [PW-1:0]           prio_q;
  logic [POINTER_BITS-1:0] ctx_q;

  // Values carried from the save step of a switch.
  logic                    run_ok;
  logic [PW-1:0]           run_prio;
  logic [POINTER_BITS-1:0] run_ctx;

  // Scan bookkeeping: the entry whose read data arrives this cycle.
  logic [IW-1:0] scan_ptr;
  logic [IW-1:0] scan_first;

  // Result registers, loaded into the output stage in S_DONE.
  logic                    res_failed;
  logic [POINTER_BITS-1:0] res_resume;

  // Table: one RAM holds status, priority and context for each entry.
  logic [PROCESSES-1:0]    vld;
  logic                    vld_q;
  logic                    wr_en;
  logic [IW-1:0]           wr_addr;
  logic [EW-1:0]           wr_data;
  logic [IW-1:0]           rd_addr;
  logic [EW-1:0]           rd_data;

  pqrr_ram #(.WIDTH(EW), .DEPTH(PROCESSES)) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Fields of the entry read last cycle. An entry never written reads free.
  pqrr_pkg::status_t       e_status;
  logic [PW-1:0]           e_prio;
  logic [POINTER_BITS-1:0] e_ctx;
  logic                    e_used;

  assign e_status = pqrr_pkg::status_t'(rd_data[EW-1 -: 2]);
  assign e_prio   = rd_data[POINTER_BITS +: PW];
  assign e_ctx    = vld_q ? rd_data[POINTER_BITS-1:0] : '0;
  assign e_used   = e_ctx != '0;

  logic accept;
  logic in_range;
  logic [IW-1:0] scan_next;
  logic [IW-1:0] first_next;
  logic [IW-1:0] scan_start;

  assign req.ready  = (state == S_IDLE);
  assign accept     = req.valid && req.ready;
  assign in_range   = (prio_q >= min_prio) && (prio_q <= max_prio);
  assign scan_next  = (scan_ptr == LAST_ID) ? '0 : scan_ptr + 1'b1;
  assign scan_start = (running_mode == pqrr_pkg::MODE_PROC) ? running_entry : '0;
  assign first_next = (scan_start == LAST_ID) ? '0 : scan_start + 1'b1;

  // Read address: the addressed entry (or the running one for a switch) at
  // acceptance, the preferred entry before the pick, then the scan.
  always_comb begin
    rd_addr = scan_next;
    case (state)
      S_IDLE: begin
        if (req.operation == pqrr_pkg::OP_SWITCH) begin
          rd_addr = running_entry;
        end else begin
          rd_addr = IW'(req.process_id);
        end
      end
      S_PREF_RD: rd_addr = preferred_entry;
      S_PREF:    rd_addr = first_next;
      default:   rd_addr = scan_next;
    endcase
  end

  always_ff @(posedge clk) begin
    vld_q <= vld[rd_addr];
  end

  // Configuration port.
  always_ff @(posedge clk) begin
    if (rst) begin
      min_prio     <= pqrr_pkg::MIN_PRIO_RST;
      max_prio     <= pqrr_pkg::MAX_PRIO_RST;
      default_prio <= pqrr_pkg::DEFAULT_PRIO_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        pqrr_pkg::CFG_MIN_PRIO:     min_prio     <= cfg_data;
        pqrr_pkg::CFG_MAX_PRIO:     max_prio     <= cfg_data;
        pqrr_pkg::CFG_DEFAULT_PRIO: default_prio <= cfg_data;
        default: ;
      endcase
    end
  end

  // Table write port, driven by the step that changes an entry.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = id_q;
    wr_data = {pqrr_pkg::ST_READY, e_prio, e_ctx};
    case (state)
      S_EXEC: begin
        if (op_raw == pqrr_pkg::OP_SWITCH) begin
          wr_addr = running_entry;
          wr_data = {(e_status == pqrr_pkg::ST_RUNNING) ? pqrr_pkg::ST_READY : e_status,
                     e_prio, ctx_q};
          wr_en   = (running_mode == pqrr_pkg::MODE_PROC);
        end else begin
          case (op_raw)
            pqrr_pkg::OP_CREATE: begin
              wr_en   = id_ok;
              wr_data = {pqrr_pkg::ST_READY, in_range ? prio_q : default_prio, ctx_q};
            end
            pqrr_pkg::OP_KILL: begin
              wr_en   = id_ok && e_used && (e_status != pqrr_pkg::ST_KILLED);
              wr_data = {pqrr_pkg::ST_KILLED, e_prio, {POINTER_BITS{1'b0}}};
            end
            pqrr_pkg::OP_BLOCK: begin
              wr_en   = id_ok && e_used;
              wr_data = {pqrr_pkg::ST_BLOCKED, e_prio, e_ctx};
            end
            pqrr_pkg::OP_UNBLOCK: begin
              wr_en   = id_ok && e_used && (e_status != pqrr_pkg::ST_READY) &&
                        (e_status != pqrr_pkg::ST_RUNNING);
              wr_data = {pqrr_pkg::ST_READY, e_prio, e_ctx};
            end
            pqrr_pkg::OP_SET_PRIO: begin
              wr_en   = id_ok && e_used && in_range;
              wr_data = {e_status, prio_q, e_ctx};
            end
            default: wr_en = 1'b0;
          endcase
        end
      end
      S_PREF: begin
        if (preferred_valid && e_used && e_status == pqrr_pkg::ST_READY) begin
          wr_en   = 1'b1;
          wr_addr = preferred_entry;
          wr_data = {pqrr_pkg::ST_RUNNING, e_prio, e_ctx};
        end else if (run_ok) begin
          wr_en   = 1'b1;
          wr_addr = running_entry;
          wr_data = {pqrr_pkg::ST_RUNNING, run_prio, run_ctx};
        end
      end
      S_SCAN: begin
        wr_addr = scan_ptr;
        wr_data = {pqrr_pkg::ST_RUNNING, e_prio, e_ctx};
        wr_en   = e_used && (e_status == pqrr_pkg::ST_READY);
      end
      default: wr_en = 1'b0;
    endcase
  end

  // Valid bits: set on every write, cleared only by reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (wr_en) begin
      vld[wr_addr] <= 1'b1;
    end
  end

  // Controller.
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      running_entry   <= '0;
      running_mode    <= pqrr_pkg::MODE_KERNEL;
      preferred_entry <= '0;
      preferred_valid <= 1'b0;
      quantum_count   <= '0;
      kernel_context  <= '0;
      rsp.valid       <= 1'b0;
    end else begin
      // In S_DONE the output stage is reloaded below instead.
      if (rsp.valid && rsp.ready && state != S_DONE) begin
        rsp.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            op_raw <= req.operation;
            id_ok  <= int'(req.process_id) < PROCESSES;
            id_q   <= IW'(req.process_id);
            prio_q <= req.priority_value;
            ctx_q  <= req.context_pointer[POINTER_BITS-1:0];
            state  <= S_EXEC;
          end
        end
        S_EXEC: begin
          res_failed <= 1'b0;
          res_resume <= '0;
          state      <= S_DONE;
          case (op_raw)
            pqrr_pkg::OP_CREATE: begin
              res_failed <= !id_ok || (ctx_q == '0);
            end
            pqrr_pkg::OP_KILL: begin
              if (!(id_ok && e_used)) begin
                res_failed <= 1'b1;
              end else if (e_status != pqrr_pkg::ST_KILLED &&
                           running_mode == pqrr_pkg::MODE_PROC && running_entry == id_q) begin
                running_mode  <= pqrr_pkg::MODE_NONE;
                running_entry <= '0;
              end
            end
            pqrr_pkg::OP_BLOCK: begin
              if (!(id_ok && e_used)) begin
                res_failed <= 1'b1;
              end else if (running_mode == pqrr_pkg::MODE_KERNEL) begin
                quantum_count <= '0;
              end
            end
            pqrr_pkg::OP_UNBLOCK: begin
              if (!(id_ok && e_used)) begin
                res_failed <= 1'b1;
              end else if (e_status != pqrr_pkg::ST_READY &&
                           e_status != pqrr_pkg::ST_RUNNING &&
                           e_prio >= (max_prio >> 1)) begin
                preferred_entry <= id_q;
                preferred_valid <= 1'b1;
              end
            end
            pqrr_pkg::OP_SET_PRIO: begin
              res_failed <= !(id_ok && e_used && in_range);
            end
            pqrr_pkg::OP_SWITCH: begin
              // Save the interrupted context and remember whether the
              // running entry may keep the processor.
              if (running_mode == pqrr_pkg::MODE_KERNEL) begin
                kernel_context <= ctx_q;
              end
              run_prio <= e_prio;
              run_ctx  <= ctx_q;
              run_ok   <= (running_mode == pqrr_pkg::MODE_PROC) && (ctx_q != '0) &&
                          (e_status == pqrr_pkg::ST_RUNNING ||
                           e_status == pqrr_pkg::ST_READY) &&
                          (quantum_count != '0);
              state    <= S_PREF_RD;
            end
            default: res_failed <= 1'b1;
          endcase
        end
        S_PREF_RD: begin
          state <= S_PREF;
        end
        S_PREF: begin
          if (preferred_valid && e_used && e_status == pqrr_pkg::ST_READY) begin
            running_entry   <= preferred_entry;
            running_mode    <= pqrr_pkg::MODE_PROC;
            preferred_valid <= 1'b0;
            quantum_count   <= pqrr_pkg::quantum_of(e_prio, max_prio);
            res_resume      <= e_ctx;
            state           <= S_DONE;
          end else if (run_ok) begin
            quantum_count <= quantum_count - 1'b1;
            res_resume    <= run_ctx;
            state         <= S_DONE;
          end else begin
            // The read of the first scan candidate is issued this cycle.
            scan_first <= scan_start;
            scan_ptr   <= first_next;
            state      <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (e_used && e_status == pqrr_pkg::ST_READY) begin
            running_entry <= scan_ptr;
            running_mode  <= pqrr_pkg::MODE_PROC;
            quantum_count <= pqrr_pkg::quantum_of(e_prio, max_prio);
            res_resume    <= e_ctx;
            state         <= S_DONE;
          end else if (scan_ptr == scan_first) begin
            // Whole table seen with nothing ready: fall back to the kernel.
            running_entry <= '0;
            running_mode  <= pqrr_pkg::MODE_KERNEL;
            quantum_count <= '0;
            res_resume    <= kernel_context;
            state         <= S_DONE;
          end else begin
            scan_ptr <= scan_next;
          end
        end
        S_DONE: begin
          if (!rsp.valid || rsp.ready) begin
            rsp.valid          <= 1'b1;
            rsp.failed         <= res_failed;
            rsp.resume_pointer <= pqrr_pkg::WORD_PTR'(res_resume);
            rsp.running_id     <= (running_mode == pqrr_pkg::MODE_PROC) ?
                                  pqrr_pkg::ID_BITS'(running_entry) : '0;
            rsp.running_kind   <= running_mode;
            rsp.quantum_left   <= quantum_count;
            state              <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign op_q = pqrr_pkg::op_t'(op_raw);

  // An accepted word always starts execution of the operation.
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == S_EXEC)
    else $error("accepted word did not start execution");

  // Outside the process mode the running entry is held at zero.
  a_entry_zero: assert property (@(posedge clk) disable iff (rst)
    running_mode != pqrr_pkg::MODE_PROC |-> running_entry == '0)
    else $error("running entry not cleared outside process mode");

  // The table is never written while idle or while a response is pending.
  a_no_idle_write: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE || state == S_DONE) |-> !wr_en)
    else $error("table written outside an operation");

  // Only the switch reaches the scan.
  a_scan_switch: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN |-> op_q == pqrr_pkg::OP_SWITCH)
    else $error("scan entered by an operation other than switch");

endmodule

[rtl/core/pqrr_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pqrr_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module pqrr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule
